// ===== hw/rtl/mrc_pkg.sv =====
// Shared types and constants for the mister relay controller.
`default_nettype none
package mrc_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int HOUR_WIDTH      = 5;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int REQ_TDATA_WIDTH = 48;
   localparam int RSP_TDATA_WIDTH = 8;

   localparam logic [TIME_WIDTH-1:0] SPRAY_DURATION_RESET = TIME_WIDTH'(10000);
   localparam logic [TIME_WIDTH-1:0] MAX_CONTINUOUS_RESET = TIME_WIDTH'(300000);
   localparam logic [HOUR_WIDTH-1:0] MORNING_HOUR_RESET   = HOUR_WIDTH'(6);
   localparam logic [HOUR_WIDTH-1:0] EVENING_HOUR_RESET   = HOUR_WIDTH'(18);

   typedef enum logic [1:0] {
      MODE_SCHED = 2'd0,
      MODE_ON    = 2'd1,
      MODE_OFF   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE        = 3'd0,
      CMD_CLOUD_SPRAY = 3'd1,
      CMD_CLOUD_OFF   = 3'd2,
      CMD_CLOUD_AUTO  = 3'd3,
      CMD_LOCAL_SPRAY = 3'd4,
      CMD_AUTO        = 3'd5,
      CMD_MANUAL_ON   = 3'd6,
      CMD_MANUAL_OFF  = 3'd7
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SPRAY_DURATION = 3'd0,
      CSR_MAX_CONTINUOUS = 3'd1,
      CSR_MORNING_HOUR   = 3'd2,
      CSR_EVENING_HOUR   = 3'd3,
      CSR_LEGACY_LOGIC   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] spray_duration_ms;
      logic [TIME_WIDTH-1:0] max_continuous_ms;
      logic [HOUR_WIDTH-1:0] morning_hour;
      logic [HOUR_WIDTH-1:0] evening_hour;
      logic                  legacy_logic;
   } cfg_type;

   // action: 0 command event, 1 loop tick
   typedef struct packed {
      logic                  action;
      cmd_type               command_code;
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  should_work;
      logic [HOUR_WIDTH-1:0] hour_of_day;
   } item_type;

   typedef struct packed {
      logic     relay_on;
      mode_type mode_out;
      logic     run_active;
      logic     run_timed;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mrc_csr.sv =====
// Configuration register file for the mister relay controller.
`default_nettype none
module mrc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mrc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mrc_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output mrc_pkg::cfg_type                          cfg
);

   mrc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spray_duration_ms <= mrc_pkg::SPRAY_DURATION_RESET;
         cfg_ff.max_continuous_ms <= mrc_pkg::MAX_CONTINUOUS_RESET;
         cfg_ff.morning_hour      <= mrc_pkg::MORNING_HOUR_RESET;
         cfg_ff.evening_hour      <= mrc_pkg::EVENING_HOUR_RESET;
         cfg_ff.legacy_logic      <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            mrc_pkg::CSR_SPRAY_DURATION: begin
               cfg_ff.spray_duration_ms <= csr_data[mrc_pkg::TIME_WIDTH-1:0];
            end
            mrc_pkg::CSR_MAX_CONTINUOUS: begin
               cfg_ff.max_continuous_ms <= csr_data[mrc_pkg::TIME_WIDTH-1:0];
            end
            mrc_pkg::CSR_MORNING_HOUR: begin
               cfg_ff.morning_hour <= csr_data[mrc_pkg::HOUR_WIDTH-1:0];
            end
            mrc_pkg::CSR_EVENING_HOUR: begin
               cfg_ff.evening_hour <= csr_data[mrc_pkg::HOUR_WIDTH-1:0];
            end
            mrc_pkg::CSR_LEGACY_LOGIC: begin
               cfg_ff.legacy_logic <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/mrc_ctrl.sv =====
// Controller state registers and the per-beat update logic.
`default_nettype none
module mrc_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  mrc_pkg::item_type item,
   input  mrc_pkg::cfg_type  cfg,
   output mrc_pkg::result_type result
);

   // relay and in_progress always move together, so one flop carries both
   mrc_pkg::mode_type              mode_ff, mode_in;
   logic                           prog_ff, prog_in;
   logic                           timed_ff, timed_in;
   logic [mrc_pkg::TIME_WIDTH-1:0] start_ff, start_in;
   logic                           mdone_ff, mdone_in;
   logic                           edone_ff, edone_in;

   always_comb begin
      logic [mrc_pkg::TIME_WIDTH-1:0] elapsed;
      logic                           started;
      logic                           sched_start;

      mode_in     = mode_ff;
      prog_in     = prog_ff;
      timed_in    = timed_ff;
      start_in    = start_ff;
      mdone_in    = mdone_ff;
      edone_in    = edone_ff;
      elapsed     = item.now_ms - start_ff;
      started     = 1'b0;
      sched_start = 1'b0;

      if (!item.action) begin
         case (item.command_code)
            mrc_pkg::CMD_CLOUD_SPRAY, mrc_pkg::CMD_LOCAL_SPRAY: begin
               // legacy cloud spray latches manual on
               if (cfg.legacy_logic && item.command_code == mrc_pkg::CMD_CLOUD_SPRAY) begin
                  mode_in = mrc_pkg::MODE_ON;
               end
               prog_in  = 1'b1;
               start_in = item.now_ms;
               if (!cfg.legacy_logic) begin
                  timed_in = 1'b1;
               end
            end
            mrc_pkg::CMD_CLOUD_OFF, mrc_pkg::CMD_MANUAL_OFF: begin
               mode_in = mrc_pkg::MODE_OFF;
               prog_in = 1'b0;
               if (!cfg.legacy_logic) begin
                  timed_in = 1'b0;
               end
            end
            mrc_pkg::CMD_CLOUD_AUTO, mrc_pkg::CMD_AUTO: begin
               mode_in = mrc_pkg::MODE_SCHED;
            end
            mrc_pkg::CMD_MANUAL_ON: begin
               mode_in = mrc_pkg::MODE_ON;
            end
            default: begin
            end
         endcase
      end else begin
         if (!cfg.legacy_logic) begin
            // run time limits first
            if (prog_ff && timed_ff && elapsed >= cfg.spray_duration_ms) begin
               prog_in  = 1'b0;
               timed_in = 1'b0;
            end else if (prog_ff && !timed_ff && elapsed >= cfg.max_continuous_ms) begin
               mode_in  = mrc_pkg::MODE_OFF;
               prog_in  = 1'b0;
               timed_in = 1'b0;
            end
         end

         if (mode_in == mrc_pkg::MODE_ON && !prog_in) begin
            prog_in  = 1'b1;
            start_in = item.now_ms;
            started  = 1'b1;
            if (!cfg.legacy_logic) begin
               timed_in = 1'b0;
            end
         end else if (mode_in == mrc_pkg::MODE_OFF && prog_in &&
                      (cfg.legacy_logic || !timed_in)) begin
            prog_in = 1'b0;
            if (!cfg.legacy_logic) begin
               timed_in = 1'b0;
            end
         end else if (mode_in == mrc_pkg::MODE_SCHED && item.should_work) begin
            if (item.hour_of_day == cfg.morning_hour && !mdone_ff) begin
               sched_start = 1'b1;
               mdone_in    = 1'b1;
               edone_in    = 1'b0;
            end else if (item.hour_of_day == cfg.evening_hour && !edone_ff) begin
               sched_start = 1'b1;
               edone_in    = 1'b1;
               mdone_in    = 1'b0;
            end else if (item.hour_of_day != cfg.morning_hour &&
                         item.hour_of_day != cfg.evening_hour) begin
               mdone_in = 1'b0;
               edone_in = 1'b0;
            end
            if (sched_start && !prog_in) begin
               prog_in  = 1'b1;
               start_in = item.now_ms;
               started  = 1'b1;
               if (!cfg.legacy_logic) begin
                  timed_in = 1'b1;
               end
            end
            // legacy checks the spray length after scheduling; a fresh run has zero elapsed
            if (cfg.legacy_logic && prog_in &&
                ((started ? '0 : elapsed) >= cfg.spray_duration_ms)) begin
               prog_in = 1'b0;
            end
         end else if (mode_in == mrc_pkg::MODE_SCHED) begin
            if (prog_in && (cfg.legacy_logic || !timed_in)) begin
               prog_in = 1'b0;
               if (!cfg.legacy_logic) begin
                  timed_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= mrc_pkg::MODE_SCHED;
         prog_ff  <= 1'b0;
         timed_ff <= 1'b0;
         start_ff <= '0;
         mdone_ff <= 1'b0;
         edone_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         prog_ff  <= prog_in;
         timed_ff <= timed_in;
         start_ff <= start_in;
         mdone_ff <= mdone_in;
         edone_ff <= edone_in;
      end
   end

   assign result.relay_on   = prog_in;
   assign result.mode_out   = mode_in;
   assign result.run_active = prog_in;
   assign result.run_timed  = timed_in;

endmodule
`default_nettype wire

// ===== hw/rtl/mister_relay_controller_core.sv =====
// Top level of the mister relay controller: beat pipeline around the state update.
// A result beat is presented once its request beat has passed the request register,
// then the result register. Throughput: one beat per cycle unless the result side
// stalls; the request register feeds the combinational state update (one 32-bit
// subtract, compared against the limits) straight into the result register.
// Reset (synchronous, active high) empties both registers, returns the mode to auto,
// clears all run and schedule flags and loads the configuration defaults.
`default_nettype none
module mister_relay_controller_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [2:0] command_code, [34:3] now_ms, [35] should_work, [40:36] hour_of_day,
   // [47:41] zero
   input  wire logic [mrc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // [0] action (0 command event, 1 loop tick)
   input  wire logic                                req_tuser,
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] relay_on, [2:1] mode_out, [3] run_active, [4] run_timed, [7:5] zero
   output logic [mrc_pkg::RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mrc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   mrc_pkg::cfg_type    cfg;
   mrc_pkg::item_type   item_ff;
   logic                item_valid_ff;
   mrc_pkg::result_type result_in;
   mrc_pkg::result_type result_ff;
   logic                rsp_valid_ff;
   logic                advance;
   logic                step;

   // result register frees up when empty or being drained this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;

   mrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mrc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result_in)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.action       <= req_tuser;
         item_ff.command_code <= mrc_pkg::cmd_type'(req_tdata[2:0]);
         item_ff.now_ms       <= req_tdata[34:3];
         item_ff.should_work  <= req_tdata[35];
         item_ff.hour_of_day  <= req_tdata[40:36];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff.run_timed, result_ff.run_active,
                        result_ff.mode_out, result_ff.relay_on};

   // relay and run flag never disagree in a shown result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == rsp_tdata[3]))
      else $error("relay_on and run_active differ");

   // an item leaving the request register shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed beat lost before result register");

   // request side stalls only when both registers are full and output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (item_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled with room in pipeline");

   // a drained result register with nothing behind it goes empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tready && !item_valid_ff) |=> !rsp_valid_ff)
      else $error("result beat repeated");

endmodule
`default_nettype wire

// ===== bench/mister_relay_controller_core_tb.sv =====
// Self-checking bench for the mister relay controller core: directed table, then random.
`timescale 1ns / 100ps
module mister_relay_controller_core_tb;

   // One row of the directed table. When has_want is set, the typed-in status is
   // checked in place of the predicted one.
   typedef struct packed {
      mrc_pkg::item_type   beat;
      logic                has_want;
      mrc_pkg::result_type want;
   } step_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // [2:0] command_code, [34:3] now_ms, [35] should_work, [40:36] hour_of_day,
   // [47:41] zero
   logic [mrc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   // [0] action
   logic                                req_tuser = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [0] relay_on, [2:1] mode_out, [3] run_active, [4] run_timed, [7:5] zero
   logic [mrc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [mrc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [mrc_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   mister_relay_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case a beat never shows up.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor: shadow copy of the controller state and its registers.
   // ------------------------------------------------------------------
   mrc_pkg::cfg_type       regs = '{mrc_pkg::SPRAY_DURATION_RESET,
                                    mrc_pkg::MAX_CONTINUOUS_RESET,
                                    mrc_pkg::MORNING_HOUR_RESET,
                                    mrc_pkg::EVENING_HOUR_RESET, 1'b0};
   mrc_pkg::mode_type      st_mode    = mrc_pkg::MODE_SCHED;
   logic                   st_running = 1'b0;
   logic                   st_timed   = 1'b0;
   logic                   st_relay   = 1'b0;
   logic                   st_morning = 1'b0;
   logic                   st_evening = 1'b0;
   logic [mrc_pkg::TIME_WIDTH-1:0] st_start = '0;

   mrc_pkg::result_type    status_due[$];   // expected status beats, oldest first
   int                     mismatch_count = 0;
   logic [mrc_pkg::TIME_WIDTH-1:0] sim_ms = '0;   // running clock for random stimulus
   logic                   calm = 1'b0;     // no idling on either side while set
   int                     hold_req = 0;    // bump to make the receiver hold off

   // The original logic never touches the timed flag.
   function automatic void spray_start(logic [mrc_pkg::TIME_WIDTH-1:0] now, logic timed);
      st_relay   = 1'b1;
      st_running = 1'b1;
      st_start   = now;
      if (!regs.legacy_logic)
         st_timed = timed;
   endfunction

   function automatic void spray_stop();
      st_relay   = 1'b0;
      st_running = 1'b0;
      if (!regs.legacy_logic)
         st_timed = 1'b0;
   endfunction

   // Auto schedule: morning is looked at first, so equal hours favor it.
   function automatic void slot_check(logic [mrc_pkg::HOUR_WIDTH-1:0] hour,
                                      logic [mrc_pkg::TIME_WIDTH-1:0] now);
      if (hour == regs.morning_hour && !st_morning) begin
         if (!st_running)
            spray_start(now, 1'b1);
         st_morning = 1'b1;
         st_evening = 1'b0;
      end else if (hour == regs.evening_hour && !st_evening) begin
         if (!st_running)
            spray_start(now, 1'b1);
         st_evening = 1'b1;
         st_morning = 1'b0;
      end else if (hour != regs.morning_hour && hour != regs.evening_hour) begin
         st_morning = 1'b0;
         st_evening = 1'b0;
      end
   endfunction

   // Applies one beat to the shadow state and returns the status it leaves.
   function automatic mrc_pkg::result_type mist_update(mrc_pkg::item_type it);
      logic [mrc_pkg::TIME_WIDTH-1:0] elapsed;
      mrc_pkg::result_type            r;
      if (!it.action) begin
         case (it.command_code)
            mrc_pkg::CMD_CLOUD_SPRAY: begin
               // old logic latches manual on here
               if (regs.legacy_logic)
                  st_mode = mrc_pkg::MODE_ON;
               spray_start(it.now_ms, 1'b1);
            end
            mrc_pkg::CMD_LOCAL_SPRAY: spray_start(it.now_ms, 1'b1);
            mrc_pkg::CMD_CLOUD_OFF, mrc_pkg::CMD_MANUAL_OFF: begin
               st_mode = mrc_pkg::MODE_OFF;
               spray_stop();
            end
            mrc_pkg::CMD_CLOUD_AUTO, mrc_pkg::CMD_AUTO: st_mode = mrc_pkg::MODE_SCHED;
            mrc_pkg::CMD_MANUAL_ON: st_mode = mrc_pkg::MODE_ON;
            default: ;
         endcase
      end else if (!regs.legacy_logic) begin
         // elapsed time wraps with the counter width
         elapsed = it.now_ms - st_start;
         if (st_running && st_timed && elapsed >= regs.spray_duration_ms) begin
            spray_stop();
         end else if (st_running && !st_timed && elapsed >= regs.max_continuous_ms) begin
            st_mode = mrc_pkg::MODE_OFF;
            spray_stop();
         end
         if (st_mode == mrc_pkg::MODE_ON && !st_running)
            spray_start(it.now_ms, 1'b0);
         else if (st_mode == mrc_pkg::MODE_OFF && st_running && !st_timed)
            spray_stop();
         else if (st_mode == mrc_pkg::MODE_SCHED && it.should_work)
            slot_check(it.hour_of_day, it.now_ms);
         else if (st_mode == mrc_pkg::MODE_SCHED && st_running && !st_timed)
            spray_stop();
      end else begin
         if (st_mode == mrc_pkg::MODE_ON && !st_running) begin
            spray_start(it.now_ms, 1'b0);
         end else if (st_mode == mrc_pkg::MODE_OFF && st_running) begin
            spray_stop();
         end else if (st_mode == mrc_pkg::MODE_SCHED && it.should_work) begin
            slot_check(it.hour_of_day, it.now_ms);
            // old logic times every run against the spray duration, after the schedule
            elapsed = it.now_ms - st_start;
            if (st_running && elapsed >= regs.spray_duration_ms)
               spray_stop();
         end else if (st_mode == mrc_pkg::MODE_SCHED && st_running) begin
            spray_stop();
         end
      end
      r.relay_on   = st_relay;
      r.mode_out   = st_mode;
      r.run_active = st_running;
      r.run_timed  = st_timed;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sender side. Inputs move on the falling edge; acceptance is seen on
   // the rising edge, where the predictor runs.
   // ------------------------------------------------------------------
   task automatic send_item(mrc_pkg::item_type it, logic has_want,
                            mrc_pkg::result_type want);
      mrc_pkg::result_type r;
      // random gap; valid drops for the idle cycles
      while (!calm && $urandom_range(99) < 15) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {7'd0, it.hour_of_day, it.should_work, it.now_ms, it.command_code};
      do @(posedge clock); while (!req_tready);
      r = mist_update(it);
      status_due.push_back(has_want ? want : r);
   endtask

   // Drop valid, let every status beat come back, then allow the pipeline
   // (two registers deep) to settle before any register write.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(mrc_pkg::csr_index_type idx,
                            logic [mrc_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mrc_pkg::CSR_SPRAY_DURATION: regs.spray_duration_ms = value;
         mrc_pkg::CSR_MAX_CONTINUOUS: regs.max_continuous_ms = value;
         mrc_pkg::CSR_MORNING_HOUR:   regs.morning_hour = value[mrc_pkg::HOUR_WIDTH-1:0];
         mrc_pkg::CSR_EVENING_HOUR:   regs.evening_hour = value[mrc_pkg::HOUR_WIDTH-1:0];
         mrc_pkg::CSR_LEGACY_LOGIC:   regs.legacy_logic = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [mrc_pkg::TIME_WIDTH-1:0] dur,
                             logic [mrc_pkg::TIME_WIDTH-1:0] ceiling,
                             logic [mrc_pkg::HOUR_WIDTH-1:0] morning,
                             logic [mrc_pkg::HOUR_WIDTH-1:0] evening,
                             logic legacy);
      drain();
      csr_write(mrc_pkg::CSR_SPRAY_DURATION, dur);
      csr_write(mrc_pkg::CSR_MAX_CONTINUOUS, ceiling);
      csr_write(mrc_pkg::CSR_MORNING_HOUR, 32'(morning));
      csr_write(mrc_pkg::CSR_EVENING_HOUR, 32'(evening));
      csr_write(mrc_pkg::CSR_LEGACY_LOGIC, 32'(legacy));
   endtask

   // Mostly ticks on a clock that moves forward in steps of all sizes, so that
   // runs reach their duration and ceiling; hours cluster on the schedule hours.
   function automatic mrc_pkg::item_type random_item();
      mrc_pkg::item_type it;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 5)
         sim_ms = $urandom();
      else if (pick < 55)
         sim_ms = sim_ms + $urandom_range(2000);
      else if (pick < 85)
         sim_ms = sim_ms + $urandom_range(20000);
      else
         sim_ms = sim_ms + $urandom_range(400000);
      it.now_ms       = sim_ms;
      it.action       = ($urandom_range(99) < 70);
      it.command_code = mrc_pkg::cmd_type'($urandom_range(7));
      it.should_work  = ($urandom_range(99) < 80);
      pick = $urandom_range(9);
      if (pick < 4)
         it.hour_of_day = regs.morning_hour;
      else if (pick < 7)
         it.hour_of_day = regs.evening_hour;
      else
         it.hour_of_day = mrc_pkg::HOUR_WIDTH'($urandom_range(31));
      return it;
   endfunction

   task automatic random_burst(int count);
      repeat (count) send_item(random_item(), 1'b0, '0);
   endtask

   function automatic step_row_type row(logic act, mrc_pkg::cmd_type c,
                                        logic [mrc_pkg::TIME_WIDTH-1:0] now,
                                        logic work, logic [mrc_pkg::HOUR_WIDTH-1:0] hour,
                                        logic has_want, mrc_pkg::result_type want);
      step_row_type s;
      s.beat.action       = act;
      s.beat.command_code = c;
      s.beat.now_ms       = now;
      s.beat.should_work  = work;
      s.beat.hour_of_day  = hour;
      s.has_want          = has_want;
      s.want              = want;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Receiver side: random stalls, with one long hold-off on request.
   // ------------------------------------------------------------------
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 15);
         end
      end
   end

   // Status checker: each accepted beat against the oldest expectation.
   mrc_pkg::result_type oldest;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            $error("status beat %h arrived with nothing outstanding", rsp_tdata);
            mismatch_count++;
         end else begin
            oldest = status_due.pop_front();
            if (rsp_tdata[0] !== oldest.relay_on) begin
               $error("relay_on: expected %0d, got %0d", oldest.relay_on, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[2:1] !== oldest.mode_out) begin
               $error("mode_out: expected %0d, got %0d", oldest.mode_out, rsp_tdata[2:1]);
               mismatch_count++;
            end
            if (rsp_tdata[3] !== oldest.run_active) begin
               $error("run_active: expected %0d, got %0d", oldest.run_active, rsp_tdata[3]);
               mismatch_count++;
            end
            if (rsp_tdata[4] !== oldest.run_timed) begin
               $error("run_timed: expected %0d, got %0d", oldest.run_timed, rsp_tdata[4]);
               mismatch_count++;
            end
            if (rsp_tdata[7:5] !== 3'd0) begin
               $error("pad: expected 0, got %0d", rsp_tdata[7:5]);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      step_row_type directed_steps[$];

      // Hand-checked rows: typed status only where it is obvious.
      // idle tick right after reset
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'h0, 1'b0, 5'd0,
                                   1'b1, '{1'b0, mrc_pkg::MODE_SCHED, 1'b0, 1'b0}));
      // command none leaves everything alone
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_NONE, 32'hFFFF_FFFF, 1'b1, 5'd31,
                                   1'b1, '{1'b0, mrc_pkg::MODE_SCHED, 1'b0, 1'b0}));
      // one-shot just below the wrap point
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_LOCAL_SPRAY, 32'hFFFF_FFF0, 1'b0,
                                   5'd0,
                                   1'b1, '{1'b1, mrc_pkg::MODE_SCHED, 1'b1, 1'b1}));
      // elapsed across the wrap: one short of the duration, then exactly on it
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'h0000_26FF, 1'b0, 5'd0,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'h0000_2700, 1'b0, 5'd0,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_MANUAL_ON, 32'd100, 1'b0, 5'd0,
                                   1'b1, '{1'b0, mrc_pkg::MODE_ON, 1'b0, 1'b0}));
      // untimed run up to the continuous ceiling -> forced manual off
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd200, 1'b1, 5'd6,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd300199, 1'b1, 5'd6,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd300200, 1'b1, 5'd6,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_CLOUD_AUTO, 32'd300300, 1'b0, 5'd0,
                                   1'b1, '{1'b0, mrc_pkg::MODE_SCHED, 1'b0, 1'b0}));
      // morning slot, repeat in the same hour, then an out-of-range hour
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd400000, 1'b1, 5'd6,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd405000, 1'b1, 5'd6,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd410000, 1'b1, 5'd31,
                                   1'b0, '0));
      // evening slot, then cloud spray restarts the one-shot
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd420000, 1'b1, 5'd18,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_CLOUD_SPRAY, 32'd425000, 1'b0, 5'd0,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_CLOUD_OFF, 32'd426000, 1'b0, 5'd0,
                                   1'b1, '{1'b0, mrc_pkg::MODE_OFF, 1'b0, 1'b0}));
      // untimed run stopped by a tick in auto with scheduling off
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_MANUAL_ON, 32'd427000, 1'b0, 5'd0,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd428000, 1'b0, 5'd23,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_AUTO, 32'd429000, 1'b0, 5'd0,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'd430000, 1'b0, 5'd0,
                                   1'b0, '0));
      directed_steps.push_back(row(1'b0, mrc_pkg::CMD_MANUAL_OFF, 32'hFFFF_FFFF, 1'b1,
                                   5'd31,
                                   1'b1, '{1'b0, mrc_pkg::MODE_OFF, 1'b0, 1'b0}));
      directed_steps.push_back(row(1'b1, mrc_pkg::CMD_NONE, 32'h0, 1'b1, 5'd6,
                                   1'b0, '0));

      // synchronous reset, released on a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_item(directed_steps[i].beat, directed_steps[i].has_want,
                   directed_steps[i].want);

      // defaults
      random_burst(100);

      // zero duration and ceiling, extreme hours
      set_config(32'd0, 32'd0, 5'd0, 5'd23, 1'b0);
      random_burst(100);

      // old logic with equal schedule hours; receiver holds off long enough
      // to back the pipeline up into the request side
      set_config(mrc_pkg::SPRAY_DURATION_RESET, mrc_pkg::MAX_CONTINUOUS_RESET,
                 5'd5, 5'd5, 1'b1);
      hold_req++;
      random_burst(100);

      // all-ones times and out-of-range hours
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd24, 1'b1);
      random_burst(100);

      // random settings, no idling on either side
      set_config($urandom_range(30000, 1), $urandom_range(500000, 1),
                 mrc_pkg::HOUR_WIDTH'($urandom_range(31)),
                 mrc_pkg::HOUR_WIDTH'($urandom_range(31)),
                 1'($urandom_range(1)));
      calm = 1'b1;
      random_burst(100);
      calm = 1'b0;

      // fixed logic with short limits
      set_config($urandom_range(20000, 1), $urandom_range(60000, 1),
                 mrc_pkg::HOUR_WIDTH'($urandom_range(23)),
                 mrc_pkg::HOUR_WIDTH'($urandom_range(23)), 1'b0);
      random_burst(100);

      // wait out everything in flight, and any stray beats
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
